// ===== hw/rtl/fqs_pkg.sv =====
package fqs_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

    // Command codes.
    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

endpackage

// ===== hw/rtl/fifo_queue_with_statistics_top.sv =====
// Each item passes from idle through the dequeue read and write-back states (dequeues only), a scan
// of the held entries through the single memory read port and the restoring divider for the mean,
// which retires one quotient bit per cycle (scan and divider are skipped when the queue ends empty),
// to the final state that loads the result. The block takes one item at a time: o_ready is low
// from the input transfer until the result has been loaded into the output register.
// Reset (i_rst_n low, synchronous) empties the queue; slot memory is not cleared.
module fifo_queue_with_statistics_top #(
    parameter int QUEUE_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_valid,
    output logic                                                o_ready,
    input  logic                                                i_command,
    input  logic signed [VALUE_WIDTH-1:0]                       i_value,
    output logic                                                o_valid,
    input  logic                                                i_ready,
    output fqs_pkg::t_status                                    o_status,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]                    o_count,
    output logic signed [VALUE_WIDTH-1:0]                       o_front_value,
    output logic signed [VALUE_WIDTH-1:0]                       o_back_value,
    output logic signed [VALUE_WIDTH+$clog2(QUEUE_DEPTH)-1:0]   o_total,
    output logic signed [VALUE_WIDTH-1:0]                       o_mean,
    output logic signed [VALUE_WIDTH-1:0]                       o_largest,
    output logic signed [VALUE_WIDTH-1:0]                       o_smallest
);
    import fqs_pkg::*;

    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = VALUE_WIDTH + IDX_W;
    localparam int DCNT_W = $clog2(SUM_W);
    localparam int EXT_W  = SUM_W - VALUE_WIDTH;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEQ_RD,
        ST_DEQ_WB,
        ST_SCAN,
        ST_DIV,
        ST_DONE
    } t_state;

    t_state                       r_state;
    logic [IDX_W-1:0]             r_head;
    logic [IDX_W-1:0]             r_tail;
    logic [CNT_W-1:0]             r_count;
    logic signed [SUM_W-1:0]      r_sum;
    t_status                      r_status;

    // Scan pipeline
    logic [IDX_W-1:0]             r_scan_addr;
    logic                         r_scan_issued;
    logic                         r_pv;
    logic                         r_pfirst;
    logic                         r_plast;
    logic signed [VALUE_WIDTH-1:0] r_front;
    logic signed [VALUE_WIDTH-1:0] r_back;
    logic signed [VALUE_WIDTH-1:0] r_max;
    logic signed [VALUE_WIDTH-1:0] r_min;

    // Divider
    logic [SUM_W-1:0]             r_dvd;
    logic [CNT_W-1:0]             r_rem;
    logic [DCNT_W-1:0]            r_dcnt;
    logic                         r_neg;

    // Output register
    logic                         r_out_valid;
    t_status                      r_out_status;
    logic [CNT_W-1:0]             r_out_count;
    logic signed [VALUE_WIDTH-1:0] r_out_front;
    logic signed [VALUE_WIDTH-1:0] r_out_back;
    logic signed [SUM_W-1:0]      r_out_total;
    logic signed [VALUE_WIDTH-1:0] r_out_mean;
    logic signed [VALUE_WIDTH-1:0] r_out_max;
    logic signed [VALUE_WIDTH-1:0] r_out_min;

    // Slot memory
    logic [VALUE_WIDTH-1:0]       mem [QUEUE_DEPTH];
    logic [VALUE_WIDTH-1:0]       r_rdata;

    logic                         in_xfer;
    logic                         is_empty;
    logic                         is_full;
    logic                         mem_we;
    logic [IDX_W-1:0]             mem_waddr;
    logic [IDX_W-1:0]             mem_raddr;
    logic signed [SUM_W-1:0]      n_value_ext;
    logic signed [SUM_W-1:0]      n_rdata_ext;
    logic signed [VALUE_WIDTH-1:0] n_rdata;
    logic [CNT_W:0]               n_trial;
    logic                         n_qbit;
    logic [CNT_W:0]               n_rem;
    logic [SUM_W-1:0]             n_sum_abs;
    logic [SUM_W-1:0]             n_mean_full;
    logic                         out_load;

    assign in_xfer  = i_valid && o_ready;
    assign is_empty = (r_count == '0);
    assign is_full  = (r_tail == IDX_W'(QUEUE_DEPTH - 1));
    assign o_ready  = (r_state == ST_IDLE);

    // Memory port selection: the write happens in the transfer cycle of an enqueue that finds room.
    assign mem_we    = in_xfer && (i_command == CMD_ENQUEUE) && (is_empty || !is_full);
    assign mem_waddr = is_empty ? '0 : r_tail + IDX_W'(1);
    assign mem_raddr = (r_state == ST_SCAN) ? r_scan_addr : r_head;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= i_value;
        end
        r_rdata <= mem[mem_raddr];
    end

    // Sign extension of the incoming and the read value to the sum width.
    assign n_rdata     = $signed(r_rdata);
    assign n_value_ext = {{EXT_W{i_value[VALUE_WIDTH-1]}}, i_value};
    assign n_rdata_ext = {{EXT_W{r_rdata[VALUE_WIDTH-1]}}, r_rdata};

    // One restoring division step on the magnitude of the sum.
    assign n_trial = {r_rem, r_dvd[SUM_W-1]};
    assign n_qbit  = (n_trial >= {1'b0, r_count});
    assign n_rem   = n_qbit ? (n_trial - {1'b0, r_count}) : n_trial;

    assign n_sum_abs   = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign n_mean_full = r_neg ? (~r_dvd + SUM_W'(1)) : r_dvd;

    assign out_load = (r_state == ST_DONE) && (!r_out_valid || i_ready);

    // Control sequencer with queue state, scan, divider and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_head        <= '0;
            r_tail        <= '0;
            r_count       <= '0;
            r_sum         <= '0;
            r_pv          <= 1'b0;
            r_scan_issued <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_status      <= STATUS_DONE;
                        r_pv          <= 1'b0;
                        r_scan_issued <= 1'b0;
                        r_scan_addr   <= is_empty ? '0 : r_head;
                        r_state       <= ST_SCAN;
                        if (i_command == CMD_ENQUEUE) begin
                            if (is_empty) begin
                                r_head  <= '0;
                                r_tail  <= '0;
                                r_count <= CNT_W'(1);
                                r_sum   <= n_value_ext;
                            end else if (is_full) begin
                                r_status <= STATUS_FULL;
                            end else begin
                                r_tail  <= r_tail + IDX_W'(1);
                                r_count <= r_count + CNT_W'(1);
                                r_sum   <= r_sum + n_value_ext;
                            end
                        end else if (is_empty) begin
                            r_status <= STATUS_EMPTY;
                        end else begin
                            r_state <= ST_DEQ_RD;
                        end
                    end
                end
                ST_DEQ_RD: begin
                    // The front entry is being read.
                    r_state <= ST_DEQ_WB;
                end
                ST_DEQ_WB: begin
                    r_count <= r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        r_head <= '0;
                        r_tail <= '0;
                        r_sum  <= '0;
                    end else begin
                        r_head <= r_head + IDX_W'(1);
                        r_sum  <= r_sum - n_rdata_ext;
                    end
                    r_scan_addr <= r_head + IDX_W'(1);
                    r_state     <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (is_empty) begin
                        r_front <= '0;
                        r_back  <= '0;
                        r_max   <= '0;
                        r_min   <= '0;
                        r_dvd   <= '0;
                        r_neg   <= 1'b0;
                        r_state <= ST_DONE;
                    end else begin
                        // Issue side: one address per cycle from head to tail.
                        if (!r_scan_issued) begin
                            r_pv     <= 1'b1;
                            r_pfirst <= (r_scan_addr == r_head);
                            r_plast  <= (r_scan_addr == r_tail);
                            if (r_scan_addr == r_tail) begin
                                r_scan_issued <= 1'b1;
                            end else begin
                                r_scan_addr <= r_scan_addr + IDX_W'(1);
                            end
                        end else begin
                            r_pv <= 1'b0;
                        end
                        // Data side: fold the returned entry into the statistics.
                        if (r_pv) begin
                            if (r_pfirst) begin
                                r_front <= n_rdata;
                                r_max   <= n_rdata;
                                r_min   <= n_rdata;
                            end else begin
                                if (n_rdata > r_max) begin
                                    r_max <= n_rdata;
                                end
                                if (n_rdata < r_min) begin
                                    r_min <= n_rdata;
                                end
                            end
                            if (r_plast) begin
                                r_back  <= n_rdata;
                                r_dvd   <= n_sum_abs;
                                r_neg   <= r_sum[SUM_W-1];
                                r_rem   <= '0;
                                r_dcnt  <= '0;
                                r_state <= ST_DIV;
                            end
                        end
                    end
                end
                ST_DIV: begin
                    r_dvd  <= {r_dvd[SUM_W-2:0], n_qbit};
                    r_rem  <= n_rem[CNT_W-1:0];
                    r_dcnt <= r_dcnt + DCNT_W'(1);
                    if (r_dcnt == DCNT_W'(SUM_W - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            // Result register: holds until the consumer takes the transfer.
            if (out_load) begin
                r_out_valid  <= 1'b1;
                r_out_status <= r_status;
                r_out_count  <= r_count;
                r_out_front  <= r_front;
                r_out_back   <= r_back;
                r_out_total  <= r_sum;
                r_out_mean   <= $signed(n_mean_full[VALUE_WIDTH-1:0]);
                r_out_max    <= r_max;
                r_out_min    <= r_min;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_count       = r_out_count;
    assign o_front_value = r_out_front;
    assign o_back_value  = r_out_back;
    assign o_total       = r_out_total;
    assign o_mean        = r_out_mean;
    assign o_largest     = r_out_max;
    assign o_smallest    = r_out_min;

    // The count never exceeds the queue depth.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    // Between items, the head and tail span exactly the held entries.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && !is_empty) |->
            (CNT_W'(r_tail - r_head) + CNT_W'(1) == r_count))
        else $error("head and tail disagree with entry count");

    // A drained queue sits at slot 0 with a zero sum.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && is_empty) |->
            (r_head == '0 && r_tail == '0 && r_sum == '0))
        else $error("empty queue not restarted");

    // A result appears only out of the final state of an item.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result presented outside the final state");

endmodule
